// ----- rtl/core/spiral_mesh_vertex_generator_macros.svh -----
// Assertion macros shared by the spiral mesh vertex generator checkers.
`ifndef SPIRAL_MESH_VERTEX_GENERATOR_MACROS_SVH
`define SPIRAL_MESH_VERTEX_GENERATOR_MACROS_SVH

// Property sampled on the rising clock edge, masked while reset is high.
`define SMVG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on the rising clock edge that stays live through reset.
`define SMVG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/smvg_pkg.sv -----
// Package: constants, beat types, sine table and helpers for the vertex generator.
package smvg_pkg;

   // Mesh limits
   localparam int MAX_SEGMENTS = 256;
   localparam int MAX_RINGS = 256;
   localparam int MAX_TURNS = 64;

   // Quarter-wave sine table
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int PHASE_BITS = SINE_IDX_BITS + 2;
   localparam int ROM_BITS = 15;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Long division pipeline: 32 quotient bits, a few bits per stage
   localparam int DIV_BITS = 32;
   localparam int DIV_STEPS = 4;
   localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
   localparam int DIVISOR_BITS = 9;
   localparam int DIV_LANES = 5;
   localparam int LANE_CONE = 0;
   localparam int LANE_TEXV = 1;
   localparam int LANE_HEIGHT = 2;
   localparam int LANE_PHASE = 3;
   localparam int LANE_TEXU = 4;

   // Saturation bounds
   localparam logic signed [31:0] Q12_MAX = 32'sd8388607;
   localparam logic signed [31:0] Q12_MIN = -32'sd8388608;
   localparam logic signed [35:0] Q16_MAX = 36'sd2147483647;
   localparam logic signed [35:0] Q16_MIN = -36'sd2147483648;

   // Register map
   typedef enum logic [2:0] {
      CSR_CONE_WIDTH,
      CSR_TURN_RISE,
      CSR_TURN_SHIFT,
      CSR_BASE_RADIUS,
      CSR_SEGMENTS,
      CSR_RINGS,
      CSR_TURNS
   } csr_index_type;

   typedef struct packed {
      logic signed [23:0] cone_width;
      logic signed [23:0] turn_rise;
      logic signed [23:0] turn_shift;
      logic signed [23:0] base_radius;
      logic [8:0]         segments;
      logic [8:0]         rings;
      logic [6:0]         turns;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cone_width: 24'sd0,
      turn_rise: 24'sd0,
      turn_shift: 24'sd0,
      base_radius: 24'sd0,
      segments: 9'd1,
      rings: 9'd1,
      turns: 7'd1
   };

   // One division lane: numerator shifts out as quotient shifts in
   typedef struct packed {
      logic [DIV_BITS-1:0]     work;
      logic [DIVISOR_BITS-1:0] rem;
   } div_lane_type;

   typedef div_lane_type [DIV_LANES-1:0] div_lanes_type;

   // Sideband that rides along with the division lanes
   typedef struct packed {
      logic               bad;
      logic               neg_cone;
      logic               neg_height;
      logic signed [30:0] shift_t;
      logic signed [30:0] rise_t;
      logic [5:0]         turn;
   } side_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [21:0]        tex_u;
      logic [16:0]        tex_v;
      logic               range_error;
   } rsp_type;

   typedef logic [SINE_TABLE_DEPTH:0][ROM_BITS-1:0] sine_rom_type;

   // Table contents from a nine-term Taylor series in Q30, rounded to Q1.15.
   // Evaluated at elaboration only.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  rnd;
      longint       sum;
      rom = '0;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         term = ((term * x2) >> 30) / 64'd6;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd210;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd272;
         sum = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         rnd = (64'(sum) + 64'd16384) >> 15;
         rom[k] = (rnd > 64'd32767) ? 15'h7FFF : rnd[ROM_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Full-wave sine in Q1.15 from the quarter-wave table
   function automatic logic signed [15:0] sine_q15(logic [PHASE_BITS-1:0] p);
      logic [SINE_IDX_BITS:0]  idx;
      logic [ROM_BITS-1:0]     mag;
      if (p[SINE_IDX_BITS]) begin
         idx = (SINE_IDX_BITS + 1)'(SINE_TABLE_DEPTH) - {1'b0, p[SINE_IDX_BITS-1:0]};
      end else begin
         idx = {1'b0, p[SINE_IDX_BITS-1:0]};
      end
      mag = SINE_ROM[idx];
      return p[PHASE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

// ----- rtl/core/smvg_front.sv -----
// Front stage: range check, products and division numerators for one request.
module smvg_front import smvg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [8:0]    ring_index,
   input  logic [5:0]    turn_index,
   input  logic [7:0]    segment_index,
   output logic          out_valid,
   input  logic          out_ready,
   output div_lanes_type out_lanes,
   output side_type      out_side
);

   logic          valid_ff;
   div_lanes_type lanes_ff;
   div_lanes_type lanes_in;
   side_type      side_ff;
   side_type      side_in;

   logic               bad;
   logic [23:0]        cone_abs;
   logic [23:0]        rise_abs;
   logic [8:0]         ring_diff;
   logic [31:0]        cone_prod;
   logic [31:0]        rise_prod;
   logic signed [30:0] shift_t;
   logic signed [30:0] rise_t;
   logic [31:0]        num_phase;

   // Any index or register out of range
   assign bad = (cfg.segments == '0) || (cfg.segments > 9'(MAX_SEGMENTS)) ||
                (cfg.rings == '0) || (cfg.rings > 9'(MAX_RINGS)) ||
                (cfg.turns == '0) || (cfg.turns > 7'(MAX_TURNS)) ||
                (ring_index > cfg.rings) || ({1'b0, turn_index} >= cfg.turns) ||
                ({1'b0, segment_index} >= cfg.segments);

   // Magnitudes for the truncating divisions
   assign cone_abs = cfg.cone_width[23] ? (~cfg.cone_width + 24'd1) : cfg.cone_width;
   assign rise_abs = cfg.turn_rise[23] ? (~cfg.turn_rise + 24'd1) : cfg.turn_rise;
   assign ring_diff = cfg.rings - ring_index;
   // at most 2^23 * 256, fits in 32 bits
   assign cone_prod = cone_abs * ring_diff;
   assign rise_prod = rise_abs * segment_index;

   // Per-turn terms, signed
   assign shift_t = $signed(cfg.turn_shift) * $signed({1'b0, turn_index});
   assign rise_t = $signed(cfg.turn_rise) * $signed({1'b0, turn_index});

   // Rounded phase: (s*4D + N/2) / N
   assign num_phase = (32'(segment_index) << PHASE_BITS) + 32'(cfg.segments >> 1);

   always_comb begin
      lanes_in[LANE_CONE].work = cone_prod;
      lanes_in[LANE_TEXV].work = 32'(ring_index) << 16;
      lanes_in[LANE_HEIGHT].work = rise_prod;
      lanes_in[LANE_PHASE].work = num_phase;
      lanes_in[LANE_TEXU].work = 32'(segment_index) << 16;
      for (int l = 0; l < DIV_LANES; l++) begin
         lanes_in[l].rem = '0;
      end
      side_in.bad = bad;
      side_in.neg_cone = cfg.cone_width[23];
      side_in.neg_height = cfg.turn_rise[23];
      side_in.shift_t = shift_t;
      side_in.rise_t = rise_t;
      side_in.turn = turn_index;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         lanes_ff <= lanes_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;
   assign out_side = side_ff;

endmodule

// ----- rtl/core/smvg_divider.sv -----
// Pipelined radix-2 long divider: five lanes, a few quotient bits per stage.
module smvg_divider import smvg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [DIVISOR_BITS-1:0] ring_div,
   input  logic [DIVISOR_BITS-1:0] seg_div,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  div_lanes_type           in_lanes,
   input  side_type                in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output div_lanes_type           out_lanes,
   output side_type                out_side
);

   // Restoring division steps on one lane
   function automatic div_lane_type div_steps(div_lane_type lane,
                                              logic [DIVISOR_BITS-1:0] divisor);
      div_lane_type          cur;
      logic [DIVISOR_BITS:0] shifted;
      cur = lane;
      for (int j = 0; j < DIV_STEPS; j++) begin
         shifted = {cur.rem, cur.work[DIV_BITS-1]};
         if (shifted >= {1'b0, divisor}) begin
            cur.rem = DIVISOR_BITS'(shifted - {1'b0, divisor});
            cur.work = {cur.work[DIV_BITS-2:0], 1'b1};
         end else begin
            cur.rem = shifted[DIVISOR_BITS-1:0];
            cur.work = {cur.work[DIV_BITS-2:0], 1'b0};
         end
      end
      return cur;
   endfunction

   logic          valid_ff [DIV_STAGES];
   div_lanes_type lanes_ff [DIV_STAGES];
   side_type      side_ff  [DIV_STAGES];
   div_lanes_type lanes_in [DIV_STAGES];

   logic          src_valid [DIV_STAGES+1];
   div_lanes_type src_lanes [DIV_STAGES+1];
   side_type      src_side  [DIV_STAGES+1];
   logic          stage_ready [DIV_STAGES+1];

   assign src_valid[0] = in_valid;
   assign src_lanes[0] = in_lanes;
   assign src_side[0] = in_side;
   assign stage_ready[DIV_STAGES] = out_ready;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      assign stage_ready[i] = !valid_ff[i] || stage_ready[i+1];

      // Cone and tex_v lanes divide by the ring count, the rest by segments
      always_comb begin
         for (int l = 0; l < DIV_LANES; l++) begin
            lanes_in[i][l] = div_steps(src_lanes[i][l],
                                       (l == LANE_CONE || l == LANE_TEXV) ? ring_div : seg_div);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_ready[i]) begin
            valid_ff[i] <= src_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[i]) begin
            lanes_ff[i] <= lanes_in[i];
            side_ff[i] <= src_side[i];
         end
      end

      assign src_valid[i+1] = valid_ff[i];
      assign src_lanes[i+1] = lanes_ff[i];
      assign src_side[i+1] = side_ff[i];
   end

   assign in_ready = stage_ready[0];
   assign out_valid = src_valid[DIV_STAGES];
   assign out_lanes = src_lanes[DIV_STAGES];
   assign out_side = src_side[DIV_STAGES];

endmodule

// ----- rtl/core/smvg_back.sv -----
// Back end: signs, sums, saturation, sine lookup, scaling and the output register.
module smvg_back import smvg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [23:0] base_radius,
   input  logic               in_valid,
   output logic               in_ready,
   input  div_lanes_type      in_lanes,
   input  side_type           in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_type            out_rsp
);

   typedef struct packed {
      logic                  bad;
      logic signed [31:0]    q_cone;
      logic signed [31:0]    q_height;
      logic signed [30:0]    shift_t;
      logic signed [30:0]    rise_t;
      logic [PHASE_BITS-1:0] phase;
      logic [21:0]           tex_u;
      logic [16:0]           tex_v;
   } b1_type;

   typedef struct packed {
      logic               bad;
      logic signed [23:0] radius;
      logic signed [31:0] height;
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
      logic [21:0]        tex_u;
      logic [16:0]        tex_v;
   } b2_type;

   typedef struct packed {
      logic               bad;
      logic signed [39:0] prod_x;
      logic signed [39:0] prod_z;
      logic signed [31:0] height;
      logic [21:0]        tex_u;
      logic [16:0]        tex_v;
   } b3_type;

   logic    b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic    b1_ready, b2_ready, b3_ready, b4_ready;
   b1_type  b1_ff, b1_in;
   b2_type  b2_ff, b2_in;
   b3_type  b3_ff, b3_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [31:0] rsum;
   logic signed [31:0] hsum;
   logic signed [35:0] hscaled;
   logic signed [39:0] rnd_x;
   logic signed [39:0] rnd_z;

   // Stage handshakes, back to front
   assign b4_ready = !b4_valid_ff || out_ready;
   assign b3_ready = !b3_valid_ff || b4_ready;
   assign b2_ready = !b2_valid_ff || b3_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign in_ready = b1_ready;

   // B1: restore quotient signs, finish texture coordinates
   always_comb begin
      b1_in.bad = in_side.bad;
      b1_in.q_cone = in_side.neg_cone ? $signed(~in_lanes[LANE_CONE].work + 32'd1)
                                      : $signed(in_lanes[LANE_CONE].work);
      b1_in.q_height = in_side.neg_height ? $signed(~in_lanes[LANE_HEIGHT].work + 32'd1)
                                          : $signed(in_lanes[LANE_HEIGHT].work);
      b1_in.shift_t = in_side.shift_t;
      b1_in.rise_t = in_side.rise_t;
      b1_in.phase = in_lanes[LANE_PHASE].work[PHASE_BITS-1:0];
      b1_in.tex_u = {in_side.turn, 16'd0} + in_lanes[LANE_TEXU].work[21:0];
      b1_in.tex_v = in_lanes[LANE_TEXV].work[16:0];
   end

   // B2: radius and height sums with saturation, sine and cosine lookup
   assign rsum = b1_ff.q_cone + 32'(b1_ff.shift_t) + 32'(base_radius);
   assign hsum = 32'(b1_ff.rise_t) + b1_ff.q_height;
   assign hscaled = 36'(hsum) <<< 4;

   always_comb begin
      b2_in.bad = b1_ff.bad;
      if (rsum > Q12_MAX) begin
         b2_in.radius = Q12_MAX[23:0];
      end else if (rsum < Q12_MIN) begin
         b2_in.radius = Q12_MIN[23:0];
      end else begin
         b2_in.radius = rsum[23:0];
      end
      if (hscaled > Q16_MAX) begin
         b2_in.height = Q16_MAX[31:0];
      end else if (hscaled < Q16_MIN) begin
         b2_in.height = Q16_MIN[31:0];
      end else begin
         b2_in.height = hscaled[31:0];
      end
      b2_in.sine = sine_q15(b1_ff.phase);
      b2_in.cosine = sine_q15(b1_ff.phase + PHASE_BITS'(SINE_TABLE_DEPTH));
      b2_in.tex_u = b1_ff.tex_u;
      b2_in.tex_v = b1_ff.tex_v;
   end

   // B3: Q1.15 times Q12.12
   always_comb begin
      b3_in.bad = b2_ff.bad;
      b3_in.prod_x = b2_ff.sine * b2_ff.radius;
      b3_in.prod_z = b2_ff.cosine * b2_ff.radius;
      b3_in.height = b2_ff.height;
      b3_in.tex_u = b2_ff.tex_u;
      b3_in.tex_v = b2_ff.tex_v;
   end

   // B4: round half up to Q16.16; the product is below 2^39, so it always fits
   assign rnd_x = (b3_ff.prod_x + 40'sd1024) >>> 11;
   assign rnd_z = (b3_ff.prod_z + 40'sd1024) >>> 11;

   always_comb begin
      if (b3_ff.bad) begin
         rsp_in = '0;
         rsp_in.range_error = 1'b1;
      end else begin
         rsp_in.pos_x = rnd_x[31:0];
         rsp_in.pos_y = b3_ff.height;
         rsp_in.pos_z = rnd_z[31:0];
         rsp_in.tex_u = b3_ff.tex_u;
         rsp_in.tex_v = b3_ff.tex_v;
         rsp_in.range_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         if (b1_ready) begin
            b1_valid_ff <= in_valid;
         end
         if (b2_ready) begin
            b2_valid_ff <= b1_valid_ff;
         end
         if (b3_ready) begin
            b3_valid_ff <= b2_valid_ff;
         end
         if (b4_ready) begin
            b4_valid_ff <= b3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_ready) begin
         b1_ff <= b1_in;
      end
      if (b2_ready) begin
         b2_ff <= b2_in;
      end
      if (b3_ready) begin
         b3_ff <= b3_in;
      end
      if (b4_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = b4_valid_ff;
   assign out_rsp = rsp_ff;

endmodule

// ----- rtl/core/spiral_mesh_vertex_generator.sv -----
// Spiral mesh vertex generator: one vertex (position, texture, range flag) per
// request beat of ring, turn and segment index. The block is fully pipelined and
// takes a new request every clock while the result side keeps up. A request runs
// through thirteen register stages, the first loaded at the edge that accepts it:
// one stage for the range check and products, eight for the 32-bit long divider
// (four quotient bits per stage, five lanes side by side for radius, height, phase
// and both texture coordinates), and four for sums, sine table lookup, scaling and
// the output register. Stalls on the result side back up through the stages
// without loss; empty stages are filled while a result waits. Registers are to be
// written over the csr port only while no request is in flight; the block itself
// does not enforce this. An index beyond the register map is ignored.
module spiral_mesh_vertex_generator import smvg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_ring_index,
   input  logic [5:0]  req_turn_index,
   input  logic [7:0]  req_segment_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [21:0] rsp_tex_u,
   output logic [16:0] rsp_tex_v,
   output logic        rsp_range_error,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic          front_valid, front_ready;
   div_lanes_type front_lanes;
   side_type      front_side;
   logic          div_valid, div_ready;
   div_lanes_type div_lanes;
   side_type      div_side;
   rsp_type       rsp;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CONE_WIDTH:  cfg_in.cone_width = csr_wdata;
            CSR_TURN_RISE:   cfg_in.turn_rise = csr_wdata;
            CSR_TURN_SHIFT:  cfg_in.turn_shift = csr_wdata;
            CSR_BASE_RADIUS: cfg_in.base_radius = csr_wdata;
            CSR_SEGMENTS:    cfg_in.segments = csr_wdata[8:0];
            CSR_RINGS:       cfg_in.rings = csr_wdata[8:0];
            CSR_TURNS:       cfg_in.turns = csr_wdata[6:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smvg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .ring_index    (req_ring_index),
      .turn_index    (req_turn_index),
      .segment_index (req_segment_index),
      .out_valid     (front_valid),
      .out_ready     (front_ready),
      .out_lanes     (front_lanes),
      .out_side      (front_side)
   );

   smvg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ring_div  (cfg_ff.rings),
      .seg_div   (cfg_ff.segments),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_lanes  (front_lanes),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_lanes (div_lanes),
      .out_side  (div_side)
   );

   smvg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .base_radius (cfg_ff.base_radius),
      .in_valid    (div_valid),
      .in_ready    (div_ready),
      .in_lanes    (div_lanes),
      .in_side     (div_side),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_rsp     (rsp)
   );

   assign rsp_pos_x = rsp.pos_x;
   assign rsp_pos_y = rsp.pos_y;
   assign rsp_pos_z = rsp.pos_z;
   assign rsp_tex_u = rsp.tex_u;
   assign rsp_tex_v = rsp.tex_v;
   assign rsp_range_error = rsp.range_error;

endmodule

// ----- rtl/core/smvg_checker.sv -----
// Port-level checker for the spiral mesh vertex generator, bound to the top level.
`include "spiral_mesh_vertex_generator_macros.svh"

module smvg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [31:0] rsp_pos_x,
   input logic signed [31:0] rsp_pos_y,
   input logic signed [31:0] rsp_pos_z,
   input logic [21:0] rsp_tex_u,
   input logic [16:0] rsp_tex_v,
   input logic        rsp_range_error
);

   // A stalled result beat holds
   `SMVG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_pos_z) && $stable(rsp_tex_u) && $stable(rsp_tex_v) && $stable(rsp_range_error), "stalled result beat changed")

   // Out-of-range requests carry zero payload
   `SMVG_ASSERT(a_err_zero, clock, reset, rsp_valid && rsp_range_error |-> rsp_pos_x == 0 && rsp_pos_y == 0 && rsp_pos_z == 0 && rsp_tex_u == 0 && rsp_tex_v == 0, "range error beat with nonzero payload")

   // tex_v never exceeds one on a good beat, since the ring never exceeds the ring count
   `SMVG_ASSERT(a_texv_bound, clock, reset, rsp_valid && !rsp_range_error |-> rsp_tex_v <= 17'd65536, "tex_v above one")

   // With the output slot empty the whole pipe can move
   `SMVG_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "request stalled with empty output")

   // Reset empties the output register
   `SMVG_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind spiral_mesh_vertex_generator smvg_checker u_smvg_checker (.*);

// ----- dv/tb_spiral_mesh_vertex_generator.sv -----
// Self-checking testbench for the spiral mesh vertex generator.
`timescale 1ns / 1ps

module tb_spiral_mesh_vertex_generator;
   import smvg_pkg::*;

   localparam int SETTLE_CYCLES = 16;      // pipeline latency plus margin
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on any channel
   localparam int RX_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 75;
   localparam int FULL_CIRCLE = 4 * SINE_TABLE_DEPTH;
   localparam logic [2:0] CSR_NONE = 3'd7;  // hole in the register map

   typedef struct packed {
      logic [8:0] ring;
      logic [5:0] turn;
      logic [7:0] seg;
   } vertex_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [8:0] req_ring_index = '0;
   logic [5:0] req_turn_index = '0;
   logic [7:0] req_segment_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [31:0] rsp_pos_z;
   logic [21:0] rsp_tex_u;
   logic [16:0] rsp_tex_v;
   logic rsp_range_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Testbench copy of the register file and the sine quarter wave
   cfg_type geometry = CFG_RESET;
   longint quarter_wave [0:SINE_TABLE_DEPTH];

   vertex_req_type pending_requests [$];
   rsp_type expected_vertices [$];

   int errors = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   bit tx_hold = 1'b0;
   int rx_hold_req = 0;
   int rx_hold_ack = 0;
   int rx_hold_left = 0;
   int idle_cycles = 0;

   spiral_mesh_vertex_generator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ring_index(req_ring_index),
      .req_turn_index(req_turn_index),
      .req_segment_index(req_segment_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z),
      .rsp_tex_u(rsp_tex_u),
      .rsp_tex_v(rsp_tex_v),
      .rsp_range_error(rsp_range_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Full-circle sine in Q1.15, 4*DEPTH steps per turn
   function automatic longint wave_q15(longint ph);
      longint k;
      k = ph % SINE_TABLE_DEPTH;
      case ((ph / SINE_TABLE_DEPTH) % 4)
         0: return quarter_wave[k];
         1: return quarter_wave[SINE_TABLE_DEPTH - k];
         2: return -quarter_wave[k];
         default: return -quarter_wave[SINE_TABLE_DEPTH - k];
      endcase
   endfunction

   // Expected vertex for one request under the current register settings
   function automatic rsp_type vertex_of(vertex_req_type rq);
      longint ri, ti, si, nseg, nring, nturn;
      longint radius, height, ph, sn, cs;
      rsp_type v;
      v = '0;
      ri = longint'(rq.ring);
      ti = longint'(rq.turn);
      si = longint'(rq.seg);
      nseg = longint'(geometry.segments);
      nring = longint'(geometry.rings);
      nturn = longint'(geometry.turns);
      if (nseg == 0 || nseg > MAX_SEGMENTS || nring == 0 || nring > MAX_RINGS ||
          nturn == 0 || nturn > MAX_TURNS || ri > nring || ti >= nturn || si >= nseg) begin
         v.range_error = 1'b1;
         return v;
      end
      radius = longint'(geometry.cone_width) * (nring - ri) / nring
               + longint'(geometry.turn_shift) * ti + longint'(geometry.base_radius);
      radius = clamp(radius, Q12_MIN, Q12_MAX);
      height = longint'(geometry.turn_rise) * ti + longint'(geometry.turn_rise) * si / nseg;
      // phase rounded to the nearest table step, ties up
      ph = (si * 2 * FULL_CIRCLE + nseg) / (2 * nseg) % FULL_CIRCLE;
      sn = wave_q15(ph);
      cs = wave_q15((ph + SINE_TABLE_DEPTH) % FULL_CIRCLE);
      v.pos_x = 32'(clamp((sn * radius + 1024) >>> 11, Q16_MIN, Q16_MAX));
      v.pos_y = 32'(clamp(height * 16, Q16_MIN, Q16_MAX));
      v.pos_z = 32'(clamp((cs * radius + 1024) >>> 11, Q16_MIN, Q16_MAX));
      v.tex_u = 22'((ti << 16) + (si << 16) / nseg);
      v.tex_v = 17'((ri << 16) / nring);
      return v;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Register write; the shadow copy follows on acceptance
   task automatic csr_write(logic [2:0] idx, logic [23:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CONE_WIDTH: geometry.cone_width = data;
         CSR_TURN_RISE: geometry.turn_rise = data;
         CSR_TURN_SHIFT: geometry.turn_shift = data;
         CSR_BASE_RADIUS: geometry.base_radius = data;
         CSR_SEGMENTS: geometry.segments = data[8:0];
         CSR_RINGS: geometry.rings = data[8:0];
         CSR_TURNS: geometry.turns = data[6:0];
         default: ;
      endcase
   endtask

   task automatic program_geometry(logic [23:0] cw, logic [23:0] tr, logic [23:0] ts,
                                   logic [23:0] br, logic [8:0] nseg, logic [8:0] nring,
                                   logic [6:0] nturn);
      csr_write(CSR_CONE_WIDTH, cw);
      csr_write(CSR_TURN_RISE, tr);
      csr_write(CSR_TURN_SHIFT, ts);
      csr_write(CSR_BASE_RADIUS, br);
      csr_write(CSR_SEGMENTS, {15'd0, nseg});
      csr_write(CSR_RINGS, {15'd0, nring});
      csr_write(CSR_TURNS, {17'd0, nturn});
   endtask

   // Full range, or a small magnitude of either sign
   function automatic logic [23:0] random_length();
      logic [23:0] mag;
      mag = 24'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
         0: return 24'($urandom());
         1: return -mag;
         default: return mag;
      endcase
   endfunction

   task automatic queue_vertex(int ring, int turn, int seg);
      vertex_req_type rq;
      rq.ring = 9'(ring);
      rq.turn = 6'(turn);
      rq.seg = 8'(seg);
      pending_requests.push_back(rq);
   endtask

   // Wait for the pipeline to empty out
   task automatic settle();
      while (pending_requests.size() != 0 || req_valid || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: predict on acceptance, then offer the next beat
   always @(posedge clock) begin : request_driver
      vertex_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_vertices.push_back(vertex_of('{ring: req_ring_index,
                                                    turn: req_turn_index,
                                                    seg: req_segment_index}));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && !tx_hold &&
                $urandom_range(0, 99) >= tx_idle_pct) begin
               nxt = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_ring_index <= nxt.ring;
               req_turn_index <= nxt.turn;
               req_segment_index <= nxt.seg;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t: result beat with nothing expected, got x=%0d y=%0d z=%0d",
                        $time, rsp_pos_x, rsp_pos_y, rsp_pos_z);
               errors++;
            end else begin
               want = expected_vertices.pop_front();
               check_field("pos_x", longint'(want.pos_x), longint'(rsp_pos_x));
               check_field("pos_y", longint'(want.pos_y), longint'(rsp_pos_y));
               check_field("pos_z", longint'(want.pos_z), longint'(rsp_pos_z));
               check_field("tex_u", longint'(want.tex_u), longint'(rsp_tex_u));
               check_field("tex_v", longint'(want.tex_v), longint'(rsp_tex_v));
               check_field("range_error", longint'(want.range_error),
                           longint'(rsp_range_error));
            end
         end
         if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog: no beat on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** spiral_mesh_vertex_generator: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      longint unsigned x, x2, term, n;
      longint sum, rnd;
      int ring, turn, seg;

      // Quarter-wave table: nine Taylor terms in Q30, rounded to Q1.15
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (n = 1; n <= 8; n++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) sum = 0;
         rnd = (sum + 16384) >>> 15;
         quarter_wave[k] = (rnd > 32767) ? 32767 : rnd;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: rings 0 and 1 at turn 0, segment 0 are legal; other indices are not
      queue_vertex(0, 0, 0);
      queue_vertex(1, 0, 0);
      queue_vertex(2, 0, 0);
      queue_vertex(0, 1, 0);
      queue_vertex(0, 0, 1);
      settle();

      // Largest mesh, all lengths at the top: radius and height saturate
      program_geometry(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 9'd256, 9'd256, 7'd64);
      queue_vertex(0, 0, 0);
      queue_vertex(256, 63, 255);
      queue_vertex(128, 32, 64);
      queue_vertex(256, 0, 255);
      queue_vertex(0, 63, 0);
      settle();

      // Most negative lengths, odd division counts, ring and segment past the end
      program_geometry(24'h800000, 24'h800000, 24'h800000, 24'h800000, 9'd3, 9'd5, 7'd64);
      queue_vertex(0, 0, 0);
      queue_vertex(5, 63, 2);
      queue_vertex(6, 0, 0);
      queue_vertex(0, 0, 3);
      queue_vertex(3, 40, 1);
      settle();

      // Register values out of range reject every request
      csr_write(CSR_SEGMENTS, 24'd0);
      queue_vertex(0, 0, 0);
      settle();
      csr_write(CSR_SEGMENTS, 24'd300);
      queue_vertex(1, 10, 5);
      settle();
      csr_write(CSR_SEGMENTS, 24'd8);
      csr_write(CSR_RINGS, 24'd0);
      queue_vertex(0, 0, 0);
      settle();
      csr_write(CSR_RINGS, 24'd511);
      queue_vertex(2, 3, 4);
      settle();
      csr_write(CSR_RINGS, 24'd4);
      csr_write(CSR_TURNS, 24'd0);
      queue_vertex(0, 0, 0);
      settle();
      csr_write(CSR_TURNS, 24'd127);
      queue_vertex(1, 1, 1);
      settle();
      // unmapped index leaves everything as it was
      csr_write(CSR_TURNS, 24'd3);
      csr_write(CSR_NONE, 24'hFFFFFF);
      queue_vertex(4, 2, 7);
      queue_vertex(2, 3, 0);
      settle();

      // Random phases across the idle mixes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            1: begin tx_idle_pct = 67; rx_stall_pct = 0; end
            2: begin tx_idle_pct = 0; rx_stall_pct = 67; end
            default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
         endcase
         if (ph == 3) begin
            program_geometry(random_length(), random_length(), random_length(),
                             random_length(), 9'd1, 9'd1, 7'd1);
         end else if (ph == 4) begin
            program_geometry(random_length(), random_length(), random_length(),
                             random_length(), 9'd256, 9'd256, 7'd64);
         end else begin
            program_geometry(random_length(), random_length(), random_length(),
                             random_length(), 9'($urandom_range(1, 256)),
                             9'($urandom_range(1, 256)), 7'($urandom_range(1, 64)));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 88) begin
               ring = $urandom_range(0, geometry.rings);
               turn = $urandom_range(0, geometry.turns - 1);
               seg = $urandom_range(0, geometry.segments - 1);
            end else begin
               ring = $urandom_range(0, 256);
               turn = $urandom_range(0, 63);
               seg = $urandom_range(0, 255);
            end
            queue_vertex(ring, turn, seg);
         end
         if (ph == 0) begin
            // long receiver hold while requests keep coming, then a full drain
            rx_hold_req++;
            while (pending_requests.size() > 30) @(posedge clock);
            tx_hold = 1'b1;
            while (req_valid || expected_vertices.size() != 0) @(posedge clock);
            tx_hold = 1'b0;
         end
         settle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("** spiral_mesh_vertex_generator: PASSED **");
      end else begin
         $display("** spiral_mesh_vertex_generator: FAILED **");
      end
      $finish;
   end

endmodule
